/* hw/rtl/mcr_pkg.sv */
// ----------------------------------------------------------------------------
// mcr_pkg
// Shared constants for the circle rasteriser: command codes, decision
// variable terms, points per group with their index type, and queue depth.
// ----------------------------------------------------------------------------
package mcr_pkg;

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_STEP  = 1'b1;

  localparam int DEC_INIT    = 3;
  localparam int DEC_INC_NEG = 6;
  localparam int DEC_INC_POS = 10;

  localparam int POINTS_PER_GROUP = 8;
  localparam int POINT_IDX_BITS   = $clog2(POINTS_PER_GROUP);

  typedef logic [POINT_IDX_BITS-1:0] point_idx_t;

  localparam point_idx_t LAST_POINT = point_idx_t'(POINTS_PER_GROUP - 1);

  localparam int QUEUE_DEPTH = 2;

endpackage

/* hw/rtl/mcr_front.sv */
// ----------------------------------------------------------------------------
// mcr_front
// Takes commands, holds the octant position and decision variable, and
// hands one group descriptor per start or live step to the group queue.
// ----------------------------------------------------------------------------
module mcr_front #(
  parameter int COORD_BITS  = 12,
  parameter int RADIUS_BITS = 11
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  logic                   cmd,
  input  logic [COORD_BITS-1:0]  center_x,
  input  logic [COORD_BITS-1:0]  center_y,
  input  logic [RADIUS_BITS-1:0] radius,
  input  logic                   q_full,
  output logic                   q_push,
  output logic [RADIUS_BITS-1:0] grp_x,
  output logic [RADIUS_BITS-1:0] grp_y,
  output logic [COORD_BITS-1:0]  grp_cx,
  output logic [COORD_BITS-1:0]  grp_cy,
  output logic                   grp_done
);
  import mcr_pkg::*;

  localparam int DW = RADIUS_BITS + 5;
  localparam int CW = RADIUS_BITS + 2;

  logic [RADIUS_BITS-1:0] octant_x;
  logic [RADIUS_BITS-1:0] octant_y;
  logic signed [DW-1:0]   decision;
  logic [COORD_BITS-1:0]  centre_col;
  logic [COORD_BITS-1:0]  centre_row;
  logic                   active;

  logic                   accept;
  logic                   start;
  logic [RADIUS_BITS-1:0] cur_x;
  logic [RADIUS_BITS-1:0] cur_y;
  logic signed [DW-1:0]   cur_d;
  logic signed [DW-1:0]   x4;
  logic signed [DW-1:0]   y4;
  logic signed [DW-1:0]   y2;
  logic                   dec_neg;
  logic signed [DW-1:0]   decision_next;
  logic [RADIUS_BITS-1:0] octant_y_next;
  logic signed [CW-1:0]   x_inc;
  logic signed [CW-1:0]   y_cmp;
  logic                   done;

  assign accept = push && !q_full;
  assign start  = (cmd == CMD_START);
  assign q_push = accept && (start || active);

  always_comb begin
    cur_x   = start ? '0 : octant_x;
    cur_y   = start ? radius : octant_y;
    y2      = $signed({{(DW-RADIUS_BITS-1){1'b0}}, radius, 1'b0});
    cur_d   = start ? (DW'(DEC_INIT) - y2) : decision;
    x4      = $signed({{(DW-RADIUS_BITS-2){1'b0}}, cur_x, 2'b00});
    y4      = $signed({{(DW-RADIUS_BITS-2){1'b0}}, cur_y, 2'b00});
    dec_neg = cur_d[DW-1];
    if (dec_neg) begin
      decision_next = cur_d + x4 + DW'(DEC_INC_NEG);
      octant_y_next = cur_y;
      y_cmp         = $signed({2'b00, cur_y});
    end else begin
      decision_next = cur_d + x4 - y4 + DW'(DEC_INC_POS);
      octant_y_next = cur_y - RADIUS_BITS'(1);
      y_cmp         = $signed({2'b00, cur_y}) - CW'(1);
    end
    x_inc = $signed({2'b00, cur_x}) + CW'(1);
    done  = x_inc > y_cmp;
  end

  assign grp_x    = cur_x;
  assign grp_y    = cur_y;
  assign grp_cx   = start ? center_x : centre_col;
  assign grp_cy   = start ? center_y : centre_row;
  assign grp_done = done;

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
    end else if (q_push) begin
      active <= !done;
    end
  end

  always_ff @(posedge clk) begin
    if (q_push) begin
      octant_x   <= cur_x + RADIUS_BITS'(1);
      octant_y   <= octant_y_next;
      decision   <= decision_next;
      centre_col <= grp_cx;
      centre_row <= grp_cy;
    end
  end

endmodule

/* hw/rtl/mcr_queue.sv */
// ----------------------------------------------------------------------------
// mcr_queue
// Short show-ahead queue of group descriptors between front and back.
// ----------------------------------------------------------------------------
module mcr_queue #(
  parameter int WIDTH = 47
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic             rd_valid,
  output logic [WIDTH-1:0] rd_data
);
  import mcr_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int NW = $clog2(QUEUE_DEPTH + 1);

  logic [WIDTH-1:0] slots [QUEUE_DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [NW-1:0]    count;
  logic             do_wr;
  logic             do_rd;

  assign full     = (count == NW'(QUEUE_DEPTH));
  assign rd_valid = (count != '0);
  assign rd_data  = slots[rd_ptr];
  assign do_wr    = wr_en && !full;
  assign do_rd    = rd_en && rd_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + NW'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - NW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_data;
    end
  end

endmodule

/* hw/rtl/mcr_back.sv */
// ----------------------------------------------------------------------------
// mcr_back
// Walks the eight symmetric points of the group at the queue head, one per
// cycle while the result stage is free or being popped, into a registered result stage.
// ----------------------------------------------------------------------------
module mcr_back #(
  parameter int COORD_BITS  = 12,
  parameter int RADIUS_BITS = 11,
  parameter int PIX_BITS    = 14
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       grp_valid,
  input  logic [RADIUS_BITS-1:0]     grp_x,
  input  logic [RADIUS_BITS-1:0]     grp_y,
  input  logic [COORD_BITS-1:0]      grp_cx,
  input  logic [COORD_BITS-1:0]      grp_cy,
  input  logic                       grp_done,
  output logic                       grp_pop,
  output logic                       empty,
  input  logic                       pop,
  output logic signed [PIX_BITS-1:0] pixel_x,
  output logic signed [PIX_BITS-1:0] pixel_y,
  output logic                       last_of_group,
  output logic                       circle_done
);
  import mcr_pkg::*;

  point_idx_t                 idx;
  logic                       out_valid;
  logic                       load;
  logic [PIX_BITS-1:0]        col_off;
  logic [PIX_BITS-1:0]        row_off;
  logic [PIX_BITS-1:0]        cx_ext;
  logic [PIX_BITS-1:0]        cy_ext;
  logic signed [PIX_BITS-1:0] pt_x;
  logic signed [PIX_BITS-1:0] pt_y;

  assign load    = grp_valid && (!out_valid || pop);
  assign grp_pop = load && (idx == LAST_POINT);
  assign empty   = !out_valid;

  // idx[2] swaps the axes, idx[0] negates the column, idx[1] the row
  always_comb begin
    cx_ext  = PIX_BITS'(grp_cx);
    cy_ext  = PIX_BITS'(grp_cy);
    col_off = idx[2] ? PIX_BITS'(grp_y) : PIX_BITS'(grp_x);
    row_off = idx[2] ? PIX_BITS'(grp_x) : PIX_BITS'(grp_y);
    pt_x    = $signed(idx[0] ? (cx_ext - col_off) : (cx_ext + col_off));
    pt_y    = $signed(idx[1] ? (cy_ext - row_off) : (cy_ext + row_off));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        idx       <= idx + point_idx_t'(1);
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      pixel_x       <= pt_x;
      pixel_y       <= pt_y;
      last_of_group <= (idx == LAST_POINT);
      circle_done   <= grp_done;
    end
  end

endmodule

/* hw/rtl/midpoint_circle_rasterizer.sv */
// ----------------------------------------------------------------------------
// midpoint_circle_rasterizer
// Bresenham circle generator: start and step commands in, plotted points out.
// ----------------------------------------------------------------------------
// Input channel: push/full. An item is taken when push is high and full low.
//   cmd = start loads centre and radius and yields the first group of eight
//   points; cmd = step yields the next group, or nothing when no circle runs.
// Result channel: empty/pop. The oldest point sits on pixel_x/pixel_y with
//   last_of_group on every eighth point and circle_done on the final group.
// Path: a command's group is written to the group queue, and its points pass
//   from the queue head through the registered result stage to the ports.
// Throughput: one point per cycle while the receiver pops, eight points per
//   producing command, set by the single registered result stage. Commands
//   themselves are taken one per cycle until the two-entry group queue fills.
// Reset (rst, synchronous): queue and result stage empty, no circle running.
// When the receiver stops popping, the result stage holds, the queue fills
//   and full rises; nothing is dropped.
// ----------------------------------------------------------------------------
module midpoint_circle_rasterizer #(
  parameter int COORD_BITS  = 12,
  parameter int RADIUS_BITS = 11,
  localparam int PIX_BITS   =
    ((COORD_BITS > RADIUS_BITS) ? COORD_BITS : RADIUS_BITS) + 2
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  output logic                       full,
  input  logic                       cmd,
  input  logic [COORD_BITS-1:0]      center_x,
  input  logic [COORD_BITS-1:0]      center_y,
  input  logic [RADIUS_BITS-1:0]     radius,
  output logic                       empty,
  input  logic                       pop,
  output logic signed [PIX_BITS-1:0] pixel_x,
  output logic signed [PIX_BITS-1:0] pixel_y,
  output logic                       last_of_group,
  output logic                       circle_done
);
  import mcr_pkg::*;

  localparam int GW = 2 * RADIUS_BITS + 2 * COORD_BITS + 1;

  logic                   q_push;
  logic                   q_full;
  logic                   q_valid;
  logic                   q_pop;
  logic [GW-1:0]          q_wr_data;
  logic [GW-1:0]          q_rd_data;
  logic [RADIUS_BITS-1:0] f_x;
  logic [RADIUS_BITS-1:0] f_y;
  logic [COORD_BITS-1:0]  f_cx;
  logic [COORD_BITS-1:0]  f_cy;
  logic                   f_done;
  logic [RADIUS_BITS-1:0] b_x;
  logic [RADIUS_BITS-1:0] b_y;
  logic [COORD_BITS-1:0]  b_cx;
  logic [COORD_BITS-1:0]  b_cy;
  logic                   b_done;

  assign full      = q_full;
  assign q_wr_data = {f_done, f_cy, f_cx, f_y, f_x};
  assign {b_done, b_cy, b_cx, b_y, b_x} = q_rd_data;

  mcr_front #(
    .COORD_BITS  (COORD_BITS),
    .RADIUS_BITS (RADIUS_BITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .cmd      (cmd),
    .center_x (center_x),
    .center_y (center_y),
    .radius   (radius),
    .q_full   (q_full),
    .q_push   (q_push),
    .grp_x    (f_x),
    .grp_y    (f_y),
    .grp_cx   (f_cx),
    .grp_cy   (f_cy),
    .grp_done (f_done)
  );

  mcr_queue #(
    .WIDTH (GW)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (q_push),
    .wr_data  (q_wr_data),
    .full     (q_full),
    .rd_en    (q_pop),
    .rd_valid (q_valid),
    .rd_data  (q_rd_data)
  );

  mcr_back #(
    .COORD_BITS  (COORD_BITS),
    .RADIUS_BITS (RADIUS_BITS),
    .PIX_BITS    (PIX_BITS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .grp_valid     (q_valid),
    .grp_x         (b_x),
    .grp_y         (b_y),
    .grp_cx        (b_cx),
    .grp_cy        (b_cy),
    .grp_done      (b_done),
    .grp_pop       (q_pop),
    .empty         (empty),
    .pop           (pop),
    .pixel_x       (pixel_x),
    .pixel_y       (pixel_y),
    .last_of_group (last_of_group),
    .circle_done   (circle_done)
  );

endmodule
